// File: hw/rtl/small_isa_time_slice_core_macros.svh
// Assertion macros shared by the core's RTL modules.
// Depends on a clock named clock and an active-high reset named reset in the module.
`ifndef SMALL_ISA_TIME_SLICE_CORE_MACROS_SVH
`define SMALL_ISA_TIME_SLICE_CORE_MACROS_SVH

// Plain property, sampled on the rising clock and switched off in reset.
`define SITS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Same-cycle implication.
`define SITS_ASSERT_IMPL(label, ante, cons, msg) \
   `SITS_ASSERT(label, (ante) |-> (cons), msg)

`endif

// File: hw/rtl/sits_pkg.sv
// Shared types and constants of the small time-slice core.
// No dependencies; used by the controller, the datapath and the top level.
package sits_pkg;

   localparam int MEM_WORDS_DEF = 256;
   localparam int FRAME_WORDS   = 6;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 80;
   localparam int ACTION_W    = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;
   localparam int STEP_W      = 3;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FRAME_WORDS - 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_PROGRAM_BASE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROGRAM_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STACK_FLOOR    = 2'd2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_WRITE_MEM = 2'd0,
      ACT_SET_CTX   = 2'd1,
      ACT_RUN       = 2'd2,
      ACT_READ_MEM  = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_ACCEPT,
      CMD_READ_WB,
      CMD_FETCH,
      CMD_END_RUN,
      CMD_LATCH_IR,
      CMD_EXEC,
      CMD_LOAD_WB,
      CMD_PUSH,
      CMD_POP_RD,
      CMD_POP_WB,
      CMD_RESULT
   } cmd_type;

   typedef enum logic [2:0] {
      EX_NEXT,
      EX_LOAD,
      EX_CALL,
      EX_RET,
      EX_STOP
   } exec_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [STEP_W-1:0]   step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic     run_go;
      exec_type exec_class;
   } dp_status_type;

endpackage

// File: hw/rtl/sits_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sits_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: hw/rtl/sits_datapath.sv
// Datapath of the core: register file, pc, sp, status, cycle clock, memory and result word.
// Depends on sits_pkg, sits_ram and the assertion macro header.
`include "small_isa_time_slice_core_macros.svh"
module sits_datapath #(
   parameter int MEM_WORDS = sits_pkg::MEM_WORDS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sits_pkg::ctrl_cmd_type            ctrl,
   output sits_pkg::dp_status_type           status,
   input  logic [sits_pkg::ACTION_W-1:0]     req_action,
   input  logic [7:0]                        req_mem_address,
   input  logic [15:0]                       req_write_value,
   input  logic [2:0]                        req_context_select,
   input  logic [15:0]                       req_slice_cycles,
   input  logic                              csr_we,
   input  logic [sits_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sits_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic [15:0]                       out_status_word,
   output logic [7:0]                        out_program_counter,
   output logic [31:0]                       out_cycle_count,
   output logic [15:0]                       out_read_value
);
   import sits_pkg::*;

   localparam int AW = $clog2(MEM_WORDS);

   localparam logic [4:0] OP_LD = 5'd0, OP_ST = 5'd1, OP_ADD = 5'd2, OP_ADC = 5'd3;
   localparam logic [4:0] OP_SUB = 5'd4, OP_SBB = 5'd5, OP_AND = 5'd6, OP_XOR = 5'd7;
   localparam logic [4:0] OP_NOT = 5'd8, OP_SHL = 5'd9, OP_SAL = 5'd10, OP_SHR = 5'd11;
   localparam logic [4:0] OP_SAR = 5'd12, OP_CMP = 5'd13, OP_GETSR = 5'd14;
   localparam logic [4:0] OP_PUTSR = 5'd15, OP_JMP = 5'd16, OP_JLT = 5'd17;
   localparam logic [4:0] OP_JEQ = 5'd18, OP_JGT = 5'd19, OP_CALL = 5'd20;
   localparam logic [4:0] OP_RET = 5'd21, OP_READ = 5'd22, OP_WRITE = 5'd23;
   localparam logic [4:0] OP_HALT = 5'd24, OP_NOP = 5'd25;

   localparam logic [2:0] STOP_SLICE = 3'd0, STOP_HALT = 3'd1, STOP_BOUND = 3'd2;
   localparam logic [2:0] STOP_OVER = 3'd3, STOP_UNDER = 3'd4, STOP_BADOP = 3'd5;
   localparam logic [2:0] STOP_READ = 3'd6, STOP_WRITE = 3'd7;

   localparam logic [2:0] CTX_PC = 3'd4, CTX_SP = 3'd5, CTX_SR = 3'd6;

   localparam logic [8:0] SP_RESET = 9'(MEM_WORDS);
   localparam logic [8:0] SP_RET_MAX = 9'(MEM_WORDS - FRAME_WORDS);

   logic [3:0][15:0] regs_ff, regs_in;
   logic [7:0]  pc_ff, pc_in;
   logic [8:0]  sp_ff, sp_in;
   logic [15:0] sr_ff, sr_in;
   logic [31:0] cyc_ff, cyc_in;
   logic [15:0] ir_ff, ir_in;
   logic [16:0] elapsed_ff, elapsed_in;
   logic [15:0] slice_ff, slice_in;
   logic [15:0] readv_ff, readv_in;
   logic [7:0]  base_ff;
   logic [8:0]  len_ff, floor_ff;
   logic [15:0] out_sr_ff, out_readv_ff;
   logic [7:0]  out_pc_ff;
   logic [31:0] out_cyc_ff;

   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [15:0]   ram_wdata, ram_rdata;

   logic [4:0]  op;
   logic [1:0]  rd, rs;
   logic        imm;
   logic [7:0]  addr8;
   logic [8:0]  ea9;
   logic [15:0] rd_val, rs_val, logic_opnd;
   logic        bound_bad, call_bad, ret_bad, pc_lt_top;
   logic [16:0] a17, opnd17, b17, extra17, sum17;
   logic        is_sub, ovf;
   exec_type    exec_class;
   logic [2:0]  stop_code;
   logic [1:0]  stop_io;
   logic        add_three;
   logic [8:0]  sp_dec;
   logic [15:0] push_word;

   function automatic logic [15:0] stop_word(input logic [15:0] sr, input logic [2:0] code,
                                             input logic [1:0] io);
      stop_word = {6'b0, io, code, sr[4:0]};
   endfunction

   sits_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_mem (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign op     = ir_ff[15:11];
   assign rd     = ir_ff[10:9];
   assign imm    = ir_ff[8];
   assign rs     = ir_ff[7:6];
   assign addr8  = ir_ff[7:0];
   assign ea9    = {1'b0, addr8} + {1'b0, base_ff};
   assign rd_val = regs_ff[rd];
   assign rs_val = regs_ff[rs];
   assign logic_opnd = imm ? {8'b0, addr8} : rs_val;
   assign sp_dec = sp_ff - 9'd1;

   assign bound_bad = {1'b0, addr8} >= len_ff;
   assign call_bad  = {1'b0, sp_ff} < ({1'b0, floor_ff} + 10'(FRAME_WORDS));
   assign ret_bad   = sp_ff > SP_RET_MAX;
   assign pc_lt_top = {2'b0, pc_ff} < ({2'b0, base_ff} + {1'b0, len_ff});

   // Add and subtract run in 17 bits: bit 16 is the carry, bit 15 the result sign.
   assign is_sub  = (op == OP_SUB) || (op == OP_SBB);
   assign a17     = {rd_val[15], rd_val};
   assign opnd17  = imm ? {{9{addr8[7]}}, addr8} : {rs_val[15], rs_val};
   assign b17     = is_sub ? (17'd0 - opnd17) : opnd17;
   always_comb begin
      extra17 = '0;
      if (op == OP_ADC && sr_ff[0]) begin
         extra17 = 17'd1;
      end else if (op == OP_SBB && sr_ff[0]) begin
         extra17 = '1;
      end
   end
   assign sum17 = a17 + b17 + extra17;
   assign ovf   = (a17[16] == b17[16]) && (a17[16] != sum17[15]);

   always_comb begin
      exec_class = EX_NEXT;
      stop_code  = STOP_SLICE;
      stop_io    = 2'b0;
      case (op)
         OP_LD: begin
            if (!imm) begin
               if (bound_bad) begin
                  exec_class = EX_STOP;
                  stop_code  = STOP_BOUND;
               end else begin
                  exec_class = EX_LOAD;
               end
            end
         end
         OP_ST, OP_JMP, OP_JLT, OP_JEQ, OP_JGT: begin
            if (bound_bad) begin
               exec_class = EX_STOP;
               stop_code  = STOP_BOUND;
            end
         end
         OP_CALL: begin
            if (bound_bad) begin
               exec_class = EX_STOP;
               stop_code  = STOP_BOUND;
            end else if (call_bad) begin
               exec_class = EX_STOP;
               stop_code  = STOP_OVER;
            end else begin
               exec_class = EX_CALL;
            end
         end
         OP_RET: begin
            if (ret_bad) begin
               exec_class = EX_STOP;
               stop_code  = STOP_UNDER;
            end else begin
               exec_class = EX_RET;
            end
         end
         OP_READ: begin
            exec_class = EX_STOP;
            stop_code  = STOP_READ;
            stop_io    = rd;
         end
         OP_WRITE: begin
            exec_class = EX_STOP;
            stop_code  = STOP_WRITE;
            stop_io    = rd;
         end
         OP_HALT: begin
            exec_class = EX_STOP;
            stop_code  = STOP_HALT;
         end
         OP_ADD, OP_ADC, OP_SUB, OP_SBB, OP_AND, OP_XOR, OP_NOT, OP_SHL, OP_SAL,
         OP_SHR, OP_SAR, OP_CMP, OP_GETSR, OP_PUTSR, OP_NOP: begin
            exec_class = EX_NEXT;
         end
         default: begin
            exec_class = EX_STOP;
            stop_code  = STOP_BADOP;
         end
      endcase
   end

   assign add_three = (exec_class == EX_LOAD) || (exec_class == EX_CALL) ||
                      (exec_class == EX_RET) || ((op == OP_ST) && (exec_class == EX_NEXT));

   always_comb begin
      case (ctrl.step)
         3'd0:    push_word = {8'b0, pc_ff};
         3'd1:    push_word = regs_ff[0];
         3'd2:    push_word = regs_ff[1];
         3'd3:    push_word = regs_ff[2];
         3'd4:    push_word = regs_ff[3];
         default: push_word = sr_ff;
      endcase
   end

   assign status.run_go     = pc_lt_top && ({1'b0, slice_ff} > elapsed_ff);
   assign status.exec_class = exec_class;

   always_comb begin
      regs_in    = regs_ff;
      pc_in      = pc_ff;
      sp_in      = sp_ff;
      sr_in      = sr_ff;
      cyc_in     = cyc_ff;
      ir_in      = ir_ff;
      elapsed_in = elapsed_ff;
      slice_in   = slice_ff;
      readv_in   = readv_ff;
      ram_we     = 1'b0;
      ram_waddr  = ea9[AW-1:0];
      ram_wdata  = rd_val;
      ram_raddr  = pc_ff[AW-1:0];
      case (ctrl.cmd)
         CMD_ACCEPT: begin
            readv_in = '0;
            case (action_type'(req_action))
               ACT_WRITE_MEM: begin
                  ram_we    = 1'b1;
                  ram_waddr = req_mem_address[AW-1:0];
                  ram_wdata = req_write_value;
               end
               ACT_SET_CTX: begin
                  if (!req_context_select[2]) begin
                     regs_in[req_context_select[1:0]] = req_write_value;
                  end else if (req_context_select == CTX_PC) begin
                     pc_in = req_write_value[7:0];
                  end else if (req_context_select == CTX_SP) begin
                     sp_in = req_write_value[8:0];
                  end else if (req_context_select == CTX_SR) begin
                     sr_in = req_write_value;
                  end
               end
               ACT_RUN: begin
                  elapsed_in = '0;
                  slice_in   = req_slice_cycles;
               end
               default: begin
                  ram_raddr = req_mem_address[AW-1:0];
               end
            endcase
         end
         CMD_READ_WB: begin
            readv_in = ram_rdata;
         end
         CMD_FETCH: begin
            ram_raddr = pc_ff[AW-1:0];
         end
         CMD_END_RUN: begin
            sr_in = stop_word(sr_ff, pc_lt_top ? STOP_SLICE : STOP_BOUND, 2'b0);
         end
         CMD_LATCH_IR: begin
            ir_in      = ram_rdata;
            pc_in      = pc_ff + 8'd1;
            cyc_in     = cyc_ff + 32'd1;
            elapsed_in = elapsed_ff + 17'd1;
         end
         CMD_EXEC: begin
            ram_raddr = ea9[AW-1:0];
            if (add_three) begin
               cyc_in     = cyc_ff + 32'd3;
               elapsed_in = elapsed_ff + 17'd3;
            end
            if (exec_class == EX_STOP) begin
               sr_in = stop_word(sr_ff, stop_code, stop_io);
            end else begin
               case (op)
                  OP_LD: begin
                     if (imm) begin
                        regs_in[rd] = {{8{addr8[7]}}, addr8};
                     end
                  end
                  OP_ST: begin
                     ram_we = 1'b1;
                  end
                  OP_ADD, OP_ADC, OP_SUB, OP_SBB: begin
                     regs_in[rd] = sum17[15:0];
                     sr_in[0]    = sum17[16];
                     sr_in[4]    = ovf;
                  end
                  OP_AND:   regs_in[rd] = rd_val & logic_opnd;
                  OP_XOR:   regs_in[rd] = rd_val ^ logic_opnd;
                  OP_NOT:   regs_in[rd] = ~rd_val;
                  OP_SHL: begin
                     sr_in[0]    = rd_val[15];
                     regs_in[rd] = {rd_val[14:0], 1'b0};
                  end
                  OP_SAL: begin
                     sr_in[0]    = rd_val[15];
                     regs_in[rd] = {rd_val[15], rd_val[13:0], 1'b0};
                  end
                  OP_SHR: begin
                     sr_in[0]    = rd_val[0];
                     regs_in[rd] = {1'b0, rd_val[15:1]};
                  end
                  OP_SAR: begin
                     sr_in[0]    = rd_val[0];
                     regs_in[rd] = {rd_val[15], rd_val[15:1]};
                  end
                  OP_CMP: begin
                     sr_in[3] = rd_val < logic_opnd;
                     sr_in[2] = rd_val == logic_opnd;
                     sr_in[1] = rd_val > logic_opnd;
                  end
                  OP_GETSR: regs_in[rd] = sr_ff;
                  OP_PUTSR: sr_in = rd_val;
                  OP_JMP:   pc_in = ea9[7:0];
                  OP_JLT:   if (sr_ff[3]) pc_in = ea9[7:0];
                  OP_JEQ:   if (sr_ff[2]) pc_in = ea9[7:0];
                  OP_JGT:   if (sr_ff[1]) pc_in = ea9[7:0];
                  default: begin
                  end
               endcase
            end
         end
         CMD_LOAD_WB: begin
            regs_in[rd] = ram_rdata;
         end
         CMD_PUSH: begin
            ram_we    = 1'b1;
            ram_waddr = sp_dec[AW-1:0];
            ram_wdata = push_word;
            sp_in     = sp_dec;
            if (ctrl.step == LAST_STEP) begin
               pc_in = ea9[7:0];
            end
         end
         CMD_POP_RD: begin
            ram_raddr = sp_ff[AW-1:0];
         end
         CMD_POP_WB: begin
            sp_in = sp_ff + 9'd1;
            case (ctrl.step)
               3'd0:    sr_in      = ram_rdata;
               3'd1:    regs_in[3] = ram_rdata;
               3'd2:    regs_in[2] = ram_rdata;
               3'd3:    regs_in[1] = ram_rdata;
               3'd4:    regs_in[0] = ram_rdata;
               default: pc_in      = ram_rdata[7:0];
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff    <= '0;
         pc_ff      <= '0;
         sp_ff      <= SP_RESET;
         sr_ff      <= '0;
         cyc_ff     <= '0;
         ir_ff      <= '0;
         elapsed_ff <= '0;
         slice_ff   <= '0;
         readv_ff   <= '0;
         base_ff    <= '0;
         len_ff     <= '0;
         floor_ff   <= '0;
      end else begin
         regs_ff    <= regs_in;
         pc_ff      <= pc_in;
         sp_ff      <= sp_in;
         sr_ff      <= sr_in;
         cyc_ff     <= cyc_in;
         ir_ff      <= ir_in;
         elapsed_ff <= elapsed_in;
         slice_ff   <= slice_in;
         readv_ff   <= readv_in;
         if (csr_we) begin
            case (csr_index)
               CSR_PROGRAM_BASE:   base_ff  <= csr_wdata[7:0];
               CSR_PROGRAM_LENGTH: len_ff   <= csr_wdata;
               CSR_STACK_FLOOR:    floor_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.cmd == CMD_RESULT) begin
         out_sr_ff    <= sr_ff;
         out_pc_ff    <= pc_ff;
         out_cyc_ff   <= cyc_ff;
         out_readv_ff <= readv_ff;
      end
   end

   assign out_status_word     = out_sr_ff;
   assign out_program_counter = out_pc_ff;
   assign out_cycle_count     = out_cyc_ff;
   assign out_read_value      = out_readv_ff;

   `SITS_ASSERT(a_elapsed_bound, ({1'b0, elapsed_ff} <= ({2'b0, slice_ff} + 18'd3)), "slice overrun")
endmodule

// File: hw/rtl/sits_controller.sv
// Sequencing state machine of the core: item acceptance, instruction steps, result hand-off.
// Depends on sits_pkg and the assertion macro header.
`include "small_isa_time_slice_core_macros.svh"
module sits_controller (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sits_pkg::ACTION_W-1:0] req_action,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  sits_pkg::dp_status_type       status,
   output sits_pkg::ctrl_cmd_type        ctrl
);
   import sits_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_CHECK, ST_FETCH, ST_EXEC, ST_LOAD,
      ST_PUSH, ST_POP_RD, ST_POP_WB, ST_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   cmd_type           cmd;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = CMD_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd = CMD_ACCEPT;
               case (action_type'(req_action))
                  ACT_RUN:      state_in = ST_CHECK;
                  ACT_READ_MEM: state_in = ST_READ;
                  default:      state_in = ST_FINISH;
               endcase
            end
         end
         ST_READ: begin
            cmd      = CMD_READ_WB;
            state_in = ST_FINISH;
         end
         ST_CHECK: begin
            if (status.run_go) begin
               cmd      = CMD_FETCH;
               state_in = ST_FETCH;
            end else begin
               cmd      = CMD_END_RUN;
               state_in = ST_FINISH;
            end
         end
         ST_FETCH: begin
            cmd      = CMD_LATCH_IR;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd     = CMD_EXEC;
            step_in = '0;
            case (status.exec_class)
               EX_LOAD: state_in = ST_LOAD;
               EX_CALL: state_in = ST_PUSH;
               EX_RET:  state_in = ST_POP_RD;
               EX_STOP: state_in = ST_FINISH;
               default: state_in = ST_CHECK;
            endcase
         end
         ST_LOAD: begin
            cmd      = CMD_LOAD_WB;
            state_in = ST_CHECK;
         end
         ST_PUSH: begin
            cmd = CMD_PUSH;
            if (step_ff == LAST_STEP) begin
               state_in = ST_CHECK;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_POP_RD: begin
            cmd      = CMD_POP_RD;
            state_in = ST_POP_WB;
         end
         ST_POP_WB: begin
            cmd = CMD_POP_WB;
            if (step_ff == LAST_STEP) begin
               state_in = ST_CHECK;
            end else begin
               step_in  = step_ff + 3'd1;
               state_in = ST_POP_RD;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd          = CMD_RESULT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign ctrl.cmd   = cmd;
   assign ctrl.step  = step_ff;

   `SITS_ASSERT(a_rsp_from_finish, $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH), "result raised outside finish")
   `SITS_ASSERT(a_step_range, (step_ff <= LAST_STEP), "frame step out of range")
   `SITS_ASSERT_IMPL(a_run_start, (state_ff == ST_IDLE && req_tvalid && req_action == ACT_RUN), (state_in == ST_CHECK), "run item did not start")
endmodule

// File: hw/rtl/small_isa_time_slice_core.sv
// Top level of the small 16-bit time-slice core: controller plus datapath.
// Depends on sits_pkg, sits_controller, sits_datapath and sits_ram.
//
//   Channel   Direction  Handshake               Contents
//   req_*     in         tvalid/tready           one host word: action and operands
//   rsp_*     out        tvalid/tready           one result word per accepted word
//   csr_*     in         write enable, no wait   program base, length, stack floor
//
// Each instruction passes through the check, fetch and execute states; a load adds a
// write-back state, a call pushes its frame one word per state and a return pops it
// with a read and a write-back state per word, as the single memory port allows one
// access a cycle. A run ends on its slice, the program bound or a stopping instruction.
// Reset is synchronous and active high; the memory itself is not cleared.
// A result waits in its output register; the next word is taken once the controller
// has handed that result over, and a stalled result holds the core in its finish state.
module small_isa_time_slice_core #(
   parameter int MEM_WORDS = sits_pkg::MEM_WORDS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // mem_address [7:0], write_value [23:8], context_select [26:24], slice_cycles [42:27]
   input  logic [sits_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // action [1:0]
   input  logic [sits_pkg::ACTION_W-1:0]      req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // stop_code [2:0], io_register [4:3], status_word [20:5], program_counter [28:21],
   // cycle_count [60:29], read_value [76:61]
   output logic [sits_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                               csr_we,
   input  logic [sits_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sits_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import sits_pkg::*;

   ctrl_cmd_type  ctrl;
   dp_status_type status;
   logic [15:0]   out_status_word;
   logic [7:0]    out_program_counter;
   logic [31:0]   out_cycle_count;
   logic [15:0]   out_read_value;

   // The controller steps through each host word and each instruction.
   sits_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .ctrl       (ctrl)
   );

   // The datapath holds all architectural state and the result register.
   sits_datapath #(.MEM_WORDS(MEM_WORDS)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .ctrl                (ctrl),
      .status              (status),
      .req_action          (req_tuser),
      .req_mem_address     (req_tdata[7:0]),
      .req_write_value     (req_tdata[23:8]),
      .req_context_select  (req_tdata[26:24]),
      .req_slice_cycles    (req_tdata[42:27]),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .out_status_word     (out_status_word),
      .out_program_counter (out_program_counter),
      .out_cycle_count     (out_cycle_count),
      .out_read_value      (out_read_value)
   );

   // The stop code and I/O register are fields of the status word.
   assign rsp_tdata = {3'b0, out_read_value, out_cycle_count, out_program_counter,
                       out_status_word, out_status_word[9:8], out_status_word[7:5]};
endmodule

// File: tb/sv/tb_small_isa_time_slice_core.sv
// Self-checking testbench for the small 16-bit time-slice core.
// Depends on sits_pkg and small_isa_time_slice_core; holds its own model of the core.
`timescale 1ns / 100ps

module tb_small_isa_time_slice_core;
   import sits_pkg::*;

   // Instruction opcodes, bits 15:11 of an instruction word.
   localparam logic [4:0] OP_LOAD = 5'd0,  OP_STORE = 5'd1,  OP_ADD = 5'd2,  OP_ADDC = 5'd3;
   localparam logic [4:0] OP_SUB = 5'd4,   OP_SUBC = 5'd5,   OP_AND = 5'd6,  OP_XOR = 5'd7;
   localparam logic [4:0] OP_NOT = 5'd8,   OP_SHL = 5'd9,    OP_SHLA = 5'd10, OP_SHR = 5'd11;
   localparam logic [4:0] OP_SHRA = 5'd12, OP_CMP = 5'd13,   OP_GETSR = 5'd14, OP_PUTSR = 5'd15;
   localparam logic [4:0] OP_JMP = 5'd16,  OP_JLT = 5'd17,   OP_JEQ = 5'd18, OP_JGT = 5'd19;
   localparam logic [4:0] OP_CALL = 5'd20, OP_RET = 5'd21,   OP_READ = 5'd22, OP_WRITE = 5'd23;
   localparam logic [4:0] OP_HALT = 5'd24, OP_NOP = 5'd25,   OP_LAST_VALID = 5'd25;

   // Stop codes left in status bits 7:5.
   localparam logic [2:0] STOP_SLICE = 3'd0, STOP_HALT = 3'd1, STOP_BOUND = 3'd2;
   localparam logic [2:0] STOP_OVER = 3'd3, STOP_UNDER = 3'd4, STOP_BAD_OP = 3'd5;
   localparam logic [2:0] STOP_READ = 3'd6, STOP_WRITE = 3'd7;

   // Context register selectors.
   localparam logic [2:0] CTX_PC = 3'd4, CTX_SP = 3'd5, CTX_SR = 3'd6, CTX_NONE = 3'd7;

   localparam int TIMEOUT_CYCLES = 20_000_000;
   localparam int RANDOM_WORDS   = 1100;

   typedef struct packed {
      logic [15:0] read_value;
      logic [31:0] cycle_count;
      logic [7:0]  program_counter;
      logic [15:0] status_word;
      logic [1:0]  io_register;
      logic [2:0]  stop_code;
   } result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [ACTION_W-1:0]    req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   small_isa_time_slice_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Shadow copy of the core's architectural state and configuration.
   // ------------------------------------------------------------------
   logic [15:0] core_mem [256];
   logic [15:0] core_reg [4];
   logic [7:0]  core_pc;
   logic [8:0]  core_sp;
   logic [15:0] core_sr;
   logic [31:0] core_cycles;
   logic [7:0]  cfg_base;
   logic [8:0]  cfg_length;
   logic [8:0]  cfg_floor;

   result_type  expected_results [$];
   int          mismatches = 0;
   int          words_sent = 0;
   int          burst_left = 0;
   int          large_slices = 0;
   longint      cycle_counter = 0;

   // Clears the upper status bits and records why the run ended; the flags survive.
   function automatic void record_stop(logic [2:0] code, logic [1:0] io);
      core_sr = {6'b0, io, code, core_sr[4:0]};
   endfunction

   // Signed add of an already extended (or negated) operand into a register,
   // updating carry (bit 0) and overflow (bit 4).
   function automatic void add_into(logic [1:0] rd, logic [31:0] b, logic [31:0] extra);
      logic [31:0] a;
      logic [31:0] sum;
      a = {{16{core_reg[rd][15]}}, core_reg[rd]};
      sum = a + b + extra;
      core_sr[0] = sum[16];
      core_sr[4] = (a[15] == b[31]) && (a[15] != sum[15]);
      core_reg[rd] = sum[15:0];
   endfunction

   // Executes one time slice on the shadow state.
   function automatic void run_time_slice(logic [15:0] slice);
      logic [31:0] start;
      logic [31:0] top;
      logic [15:0] ir;
      logic [15:0] t;
      logic [15:0] k;
      logic [31:0] b;
      logic [4:0]  op;
      logic [1:0]  rd;
      logic [1:0]  rs;
      logic        imm;
      logic [7:0]  addr;
      logic [7:0]  target;
      start = core_cycles;
      top = 32'(cfg_base) + 32'(cfg_length);
      while (32'(core_pc) < top && (core_cycles - start) < 32'(slice)) begin
         ir = core_mem[core_pc];
         core_pc = core_pc + 8'd1;
         op = ir[15:11];
         rd = ir[10:9];
         imm = ir[8];
         rs = ir[7:6];
         addr = ir[7:0];
         target = addr + cfg_base;
         core_cycles = core_cycles + 1;
         case (op)
            OP_LOAD: begin
               if (imm) begin
                  core_reg[rd] = {{8{addr[7]}}, addr};
               end else begin
                  if (9'(addr) >= cfg_length) begin record_stop(STOP_BOUND, 2'd0); return; end
                  core_reg[rd] = core_mem[target];
                  core_cycles = core_cycles + 3;
               end
            end
            OP_STORE: begin
               if (9'(addr) >= cfg_length) begin record_stop(STOP_BOUND, 2'd0); return; end
               core_mem[target] = core_reg[rd];
               core_cycles = core_cycles + 3;
            end
            OP_ADD, OP_ADDC: begin
               b = imm ? {{24{addr[7]}}, addr} : {{16{core_reg[rs][15]}}, core_reg[rs]};
               add_into(rd, b, (op == OP_ADDC) ? 32'(core_sr[0]) : 32'd0);
            end
            OP_SUB, OP_SUBC: begin
               b = imm ? {{24{addr[7]}}, addr} : {{16{core_reg[rs][15]}}, core_reg[rs]};
               add_into(rd, 32'd0 - b, (op == OP_SUBC) ? 32'd0 - 32'(core_sr[0]) : 32'd0);
            end
            OP_AND:   core_reg[rd] = core_reg[rd] & (imm ? 16'(addr) : core_reg[rs]);
            OP_XOR:   core_reg[rd] = core_reg[rd] ^ (imm ? 16'(addr) : core_reg[rs]);
            OP_NOT:   core_reg[rd] = ~core_reg[rd];
            OP_SHL: begin
               t = core_reg[rd];
               core_sr[0] = t[15];
               core_reg[rd] = {t[14:0], 1'b0};
            end
            OP_SHLA: begin
               t = core_reg[rd];
               core_sr[0] = t[15];
               core_reg[rd] = {t[15], t[13:0], 1'b0};
            end
            OP_SHR: begin
               t = core_reg[rd];
               core_sr[0] = t[0];
               core_reg[rd] = {1'b0, t[15:1]};
            end
            OP_SHRA: begin
               t = core_reg[rd];
               core_sr[0] = t[0];
               core_reg[rd] = {t[15], t[15:1]} | (t & 16'h8000);
            end
            OP_CMP: begin
               t = core_reg[rd];
               k = imm ? 16'(addr) : core_reg[rs];
               core_sr[3] = t < k;
               core_sr[2] = t == k;
               core_sr[1] = t > k;
            end
            OP_GETSR: core_reg[rd] = core_sr;
            OP_PUTSR: core_sr = core_reg[rd];
            OP_JMP, OP_JLT, OP_JEQ, OP_JGT: begin
               if (9'(addr) >= cfg_length) begin record_stop(STOP_BOUND, 2'd0); return; end
               if (op == OP_JMP || (op == OP_JLT && core_sr[3]) ||
                   (op == OP_JEQ && core_sr[2]) || (op == OP_JGT && core_sr[1]))
                  core_pc = target;
            end
            OP_CALL: begin
               if (9'(addr) >= cfg_length) begin record_stop(STOP_BOUND, 2'd0); return; end
               if (10'(core_sp) < 10'(cfg_floor) + 10'(FRAME_WORDS)) begin
                  record_stop(STOP_OVER, 2'd0);
                  return;
               end
               // Frame from the top down: pc, r0..r3, then status.
               core_sp = core_sp - 1;
               core_mem[core_sp[7:0]] = 16'(core_pc);
               for (int j = 0; j < 4; j++) begin
                  core_sp = core_sp - 1;
                  core_mem[core_sp[7:0]] = core_reg[j];
               end
               core_sp = core_sp - 1;
               core_mem[core_sp[7:0]] = core_sr;
               core_pc = target;
               core_cycles = core_cycles + 3;
            end
            OP_RET: begin
               if (core_sp > 9'(256 - FRAME_WORDS)) begin record_stop(STOP_UNDER, 2'd0); return; end
               core_sr = core_mem[core_sp[7:0]];
               core_sp = core_sp + 1;
               for (int j = 3; j >= 0; j--) begin
                  core_reg[j] = core_mem[core_sp[7:0]];
                  core_sp = core_sp + 1;
               end
               core_pc = core_mem[core_sp[7:0]][7:0];
               core_sp = core_sp + 1;
               core_cycles = core_cycles + 3;
            end
            OP_READ:  begin record_stop(STOP_READ, rd); return; end
            OP_WRITE: begin record_stop(STOP_WRITE, rd); return; end
            OP_HALT:  begin record_stop(STOP_HALT, 2'd0); return; end
            OP_NOP: ;
            default:  begin record_stop(STOP_BAD_OP, 2'd0); return; end
         endcase
      end
      record_stop((32'(core_pc) >= top) ? STOP_BOUND : STOP_SLICE, 2'd0);
   endfunction

   // Applies one host word to the shadow state and returns the result it must produce.
   function automatic result_type apply_host_word(action_type action, logic [7:0] address,
                                                  logic [15:0] value, logic [2:0] sel,
                                                  logic [15:0] slice);
      result_type r;
      r.read_value = '0;
      case (action)
         ACT_WRITE_MEM: core_mem[address] = value;
         ACT_SET_CTX: begin
            if (sel < CTX_PC) core_reg[sel[1:0]] = value;
            else if (sel == CTX_PC) core_pc = value[7:0];
            else if (sel == CTX_SP) core_sp = value[8:0];
            else if (sel == CTX_SR) core_sr = value;
         end
         ACT_RUN:      run_time_slice(slice);
         default:      r.read_value = core_mem[address];
      endcase
      r.stop_code = core_sr[7:5];
      r.io_register = core_sr[9:8];
      r.status_word = core_sr;
      r.program_counter = core_pc;
      r.cycle_count = core_cycles;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Shared stimulus tasks.
   // ------------------------------------------------------------------

   // Sends one host word. The sender works in bursts; between bursts tvalid drops
   // for a random gap. The expectation is computed at the edge of acceptance.
   task automatic send_word(action_type action, logic [7:0] address, logic [15:0] value,
                            logic [2:0] sel, logic [15:0] slice);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (req_tvalid) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tuser <= action;
      req_tdata <= {5'b0, slice, sel, value, address};
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(apply_host_word(action, address, value, sel, slice));
      words_sent++;
      burst_left--;
   endtask

   // Lets every outstanding result arrive and the core settle, so that it is idle.
   task automatic wait_until_idle();
      if (req_tvalid) req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (expected_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Writes all three configuration registers; only called while the core is idle.
   task automatic write_config(logic [7:0] base, logic [8:0] length, logic [8:0] floor_value);
      csr_we <= 1'b1;
      csr_index <= CSR_PROGRAM_BASE;
      csr_wdata <= 9'(base);
      @(posedge clock);
      csr_index <= CSR_PROGRAM_LENGTH;
      csr_wdata <= length;
      @(posedge clock);
      csr_index <= CSR_STACK_FLOOR;
      csr_wdata <= floor_value;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_base = base;
      cfg_length = length;
      cfg_floor = floor_value;
      @(posedge clock);
   endtask

   // A random instruction word; memory and branch references mostly land inside
   // the program so that runs get past the bound check.
   function automatic logic [15:0] random_instruction();
      logic [4:0] op;
      logic [7:0] addr;
      op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(26, 31))
                                        : 5'($urandom_range(0, OP_LAST_VALID));
      addr = 8'($urandom_range(0, 255));
      if (cfg_length != 0 && $urandom_range(0, 4) != 0)
         addr = 8'($urandom_range(0, (cfg_length > 256) ? 255 : cfg_length - 1));
      return {op, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), addr};
   endfunction

   // ------------------------------------------------------------------
   // Test tasks.
   // ------------------------------------------------------------------

   // Memory is undefined after reset, so every word is written before anything
   // can fetch, load or pop it.
   task automatic test_memory_fill();
      write_config(8'd0, 9'd0, 9'd0);
      for (int a = 0; a < 256; a++)
         send_word(ACT_WRITE_MEM, 8'(a), 16'($urandom), 3'd0, 16'd0);
      send_word(ACT_READ_MEM, 8'd0, 16'd0, 3'd0, 16'd0);
      send_word(ACT_READ_MEM, 8'd255, 16'd0, 3'd0, 16'd0);
      wait_until_idle();
   endtask

   // Every context selector, including the ignored one, with extreme values.
   task automatic test_context_writes();
      for (int s = 0; s < 8; s++)
         send_word(ACT_SET_CTX, 8'd0, 16'hffff, 3'(s), 16'd0);
      for (int s = 0; s < 8; s++)
         send_word(ACT_SET_CTX, 8'hff, 16'h0000, 3'(s), 16'hffff);
      send_word(ACT_SET_CTX, 8'd0, 16'h0100, CTX_SP, 16'd0);
      wait_until_idle();
   endtask

   // Each opcode, including the undefined ones, executed alone from the program start.
   task automatic test_each_opcode();
      write_config(8'd16, 9'd8, 9'd0);
      for (int op = 0; op < 32; op++) begin
         send_word(ACT_WRITE_MEM, 8'd16, {5'(op), 2'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)), 8'($urandom_range(0, 7))}, 3'd0, 16'd0);
         send_word(ACT_SET_CTX, 8'd0, 16'd16, CTX_PC, 16'd0);
         send_word(ACT_RUN, 8'd0, 16'd0, 3'd0, 16'd1);
      end
      wait_until_idle();
   endtask

   // A zero slice, a run with no program, a stack overflow, a stack underflow,
   // and the program counter wrapping past the top of memory.
   task automatic test_run_edges();
      write_config(8'd0, 9'd0, 9'd256);
      send_word(ACT_RUN, 8'd0, 16'd0, 3'd0, 16'd0);
      send_word(ACT_SET_CTX, 8'd0, 16'd0, CTX_PC, 16'd0);
      send_word(ACT_RUN, 8'd0, 16'd0, 3'd0, 16'd5);
      wait_until_idle();
      write_config(8'd40, 9'd4, 9'd256);
      send_word(ACT_WRITE_MEM, 8'd40, {OP_CALL, 2'd0, 1'b0, 8'd1}, 3'd0, 16'd0);
      send_word(ACT_SET_CTX, 8'd0, 16'd40, CTX_PC, 16'd0);
      send_word(ACT_RUN, 8'd0, 16'd0, 3'd0, 16'd10);
      send_word(ACT_WRITE_MEM, 8'd40, {OP_RET, 11'd0}, 3'd0, 16'd0);
      send_word(ACT_SET_CTX, 8'd0, 16'd256, CTX_SP, 16'd0);
      send_word(ACT_SET_CTX, 8'd0, 16'd40, CTX_PC, 16'd0);
      send_word(ACT_RUN, 8'd0, 16'd0, 3'd0, 16'd10);
      wait_until_idle();
      write_config(8'd255, 9'd256, 9'd0);
      send_word(ACT_WRITE_MEM, 8'd255, {OP_NOP, 11'd0}, 3'd0, 16'd0);
      send_word(ACT_SET_CTX, 8'd0, 16'd255, CTX_PC, 16'd0);
      send_word(ACT_RUN, 8'd0, 16'd0, 3'd0, 16'd2);
      wait_until_idle();
   endtask

   // Random programs: load a short program, set up the context, run it, sometimes
   // resume it and peek at memory. The configuration changes between phases.
   task automatic test_random_programs();
      int          target;
      int          words;
      int          span;
      logic [15:0] slice;
      logic [7:0]  base;
      logic [8:0]  length;
      logic [8:0]  floor_value;
      target = words_sent + RANDOM_WORDS;
      while (words_sent < target) begin
         wait_until_idle();
         case ($urandom_range(0, 5))
            0:       base = 8'd0;
            1:       base = 8'd255;
            default: base = 8'($urandom_range(0, 255));
         endcase
         case ($urandom_range(0, 9))
            0:       length = 9'd0;
            1:       length = 9'd256;
            2:       length = 9'($urandom_range(0, 256));
            default: length = 9'($urandom_range(4, 48));
         endcase
         case ($urandom_range(0, 7))
            0:       floor_value = 9'd256;
            1:       floor_value = 9'd0;
            default: floor_value = 9'($urandom_range(0, 200));
         endcase
         write_config(base, length, floor_value);
         for (int seq = 0; seq < 6 && words_sent < target; seq++) begin
            span = (length == 0) ? 1 : ((length > 256) ? 256 : length);
            words = $urandom_range(1, (span < 16) ? span : 16);
            for (int w = 0; w < words; w++)
               send_word(ACT_WRITE_MEM, 8'(base + $urandom_range(0, span - 1)),
                         random_instruction(), 3'd0, 16'd0);
            send_word(ACT_SET_CTX, 8'd0, 16'(8'(base + $urandom_range(0, span - 1))),
                      CTX_PC, 16'd0);
            if ($urandom_range(0, 2) == 0)
               send_word(ACT_SET_CTX, 8'd0, 16'($urandom), 3'($urandom_range(0, 7)),
                         16'($urandom));
            if ($urandom_range(0, 3) == 0)
               send_word(ACT_SET_CTX, 8'd0, 16'd256, CTX_SP, 16'd0);
            for (int r = 0; r < 3; r++) begin
               case ($urandom_range(0, 19))
                  0:       slice = 16'd0;
                  1, 2:    slice = 16'($urandom_range(61, 400));
                  3:       slice = (large_slices < 2) ? 16'hffff : 16'd1;
                  default: slice = 16'($urandom_range(1, 60));
               endcase
               if (slice == 16'hffff) large_slices++;
               send_word(ACT_RUN, 8'($urandom), 16'($urandom), 3'($urandom), slice);
               if ($urandom_range(0, 2) != 0) break;
            end
            if ($urandom_range(0, 1) == 0)
               send_word(ACT_READ_MEM, 8'($urandom), 16'($urandom), 3'($urandom), 16'd0);
         end
      end
      wait_until_idle();
   endtask

   // ------------------------------------------------------------------
   // Result side: the receiver stalls in modes of its own (always ready, random
   // back-pressure, long stalls), and every accepted word is checked.
   // ------------------------------------------------------------------
   int stall_mode = 0;
   int mode_left = 0;
   int stall_left = 0;

   function automatic void compare_field(string name, logic [31:0] expected_value,
                                         logic [31:0] actual_value);
      if (expected_value !== actual_value) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Mismatch in %s: expected %0h, got %0h", name, expected_value,
                     actual_value);
      end
   endfunction

   always @(posedge clock) begin
      result_type got;
      result_type want;
      cycle_counter++;
      if (cycle_counter > TIMEOUT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(50, 400);
         end
         mode_left--;
         if (stall_mode == 0) begin
            rsp_tready <= 1'b1;
         end else if (stall_mode == 1) begin
            rsp_tready <= ($urandom_range(0, 2) != 0);
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 30);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(result_type)-1:0];
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected result word %0h", got);
            end else begin
               want = expected_results.pop_front();
               compare_field("stop_code", 32'(want.stop_code), 32'(got.stop_code));
               compare_field("io_register", 32'(want.io_register), 32'(got.io_register));
               compare_field("status_word", 32'(want.status_word), 32'(got.status_word));
               compare_field("program_counter", 32'(want.program_counter),
                             32'(got.program_counter));
               compare_field("cycle_count", want.cycle_count, got.cycle_count);
               compare_field("read_value", 32'(want.read_value), 32'(got.read_value));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequence of tests.
   // ------------------------------------------------------------------
   initial begin
      core_reg = '{default: 16'd0};
      core_pc = '0;
      core_sp = 9'd256;
      core_sr = '0;
      core_cycles = '0;
      cfg_base = '0;
      cfg_length = '0;
      cfg_floor = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_memory_fill();
      test_context_writes();
      test_each_opcode();
      test_run_edges();
      test_random_programs();
      // Anything still queued was never answered.
      repeat (50) @(posedge clock);
      if (expected_results.size() != 0) mismatches++;
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/sits_pkg.sv
hw/rtl/sits_ram.sv
hw/rtl/sits_datapath.sv
hw/rtl/sits_controller.sv
hw/rtl/small_isa_time_slice_core.sv
tb/sv/tb_small_isa_time_slice_core.sv
